// File: design/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned OUT_W    = 72;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd5;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic clr;
    logic en;
    logic search;
  } scan_ctrl_t;

endpackage

// File: design/bounded_deque_with_search.sv
`timescale 1ns / 1ps
// An input word is taken in ST_IDLE; the deque then reads every entry held after the action in
// ST_RUN, and in ST_DONE registers the result word once the output register is free.
// Input is not ready until the result word is registered, so a new word is not taken while
// one is in flight; a result word held by m_axis_tready_i low stalls ST_DONE.
// Reset (rst_ni low, asynchronous) empties the deque and clears the reverse flag;
// stored values need no clearing.
module bounded_deque_with_search #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [bdq_pkg::DATA_W-1:0]     s_axis_tdata_i,  // value
  input  logic [bdq_pkg::ACTION_W-1:0]   s_axis_tuser_i,  // action
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found, dropped, entries[4:0], largest[31:0], smallest[31:0], zero pad
  output logic [bdq_pkg::OUT_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [PTR_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rev_q, rev_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             pend_q, pend_d;
  logic             srch_q, srch_d;
  logic             drop_q, drop_d;
  logic signed [bdq_pkg::DATA_W-1:0] key_q;

  logic             out_vld_q, out_vld_d;
  logic [bdq_pkg::OUT_W-1:0] out_q;

  logic             accept;
  logic             full;
  logic             low_end;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic             re;
  logic [bdq_pkg::DATA_W-1:0] rdata;

  bdq_pkg::scan_ctrl_t scan_ctrl;
  logic                scan_found;
  logic signed [bdq_pkg::DATA_W-1:0] scan_hi;
  logic signed [bdq_pkg::DATA_W-1:0] scan_lo;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (cnt_q >= CNT_W'(CAPACITY));

  assign tail_sum  = {1'b0, cnt_q} + (CNT_W + 1)'(first_q);
  assign tail_wrap = (tail_sum >= (CNT_W + 1)'(CAPACITY)) ?
                     tail_sum - (CNT_W + 1)'(CAPACITY) : tail_sum;

  always_comb begin
    first_d = first_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    drop_d  = 1'b0;
    we      = 1'b0;
    waddr   = PTR_W'(tail_wrap);
    low_end = 1'b0;
    case (s_axis_tuser_i)
      bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
        low_end = (s_axis_tuser_i == bdq_pkg::ACT_PUSH_FRONT) != rev_q;
        if (full) begin
          drop_d = 1'b1;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
          if (low_end) begin
            first_d = (first_q == '0) ? PTR_W'(CAPACITY - 1) : first_q - PTR_W'(1);
            waddr   = first_d;
          end
        end
      end
      bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
        low_end = (s_axis_tuser_i == bdq_pkg::ACT_POP_FRONT) != rev_q;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (low_end) begin
            first_d = (first_q == PTR_W'(CAPACITY - 1)) ? '0 : first_q + PTR_W'(1);
          end
        end
      end
      bdq_pkg::ACT_REVERSE: begin
        rev_d = !rev_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    pend_d    = 1'b0;
    srch_d    = srch_q;
    re        = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    scan_ctrl = '{clr: 1'b0, en: pend_q, search: srch_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d       = ST_RUN;
          ptr_d         = first_d;
          rem_d         = cnt_d;
          srch_d        = (s_axis_tuser_i == bdq_pkg::ACT_SEARCH);
          scan_ctrl.clr = 1'b1;
        end
      end
      ST_RUN: begin
        if (rem_q != '0) begin
          re     = 1'b1;
          pend_d = 1'b1;
          rem_d  = rem_q - CNT_W'(1);
          ptr_d  = (ptr_q == PTR_W'(CAPACITY - 1)) ? '0 : ptr_q + PTR_W'(1);
        end else if (!pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      first_q   <= '0;
      cnt_q     <= '0;
      rev_q     <= 1'b0;
      ptr_q     <= '0;
      rem_q     <= '0;
      pend_q    <= 1'b0;
      srch_q    <= 1'b0;
      drop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      pend_q    <= pend_d;
      srch_q    <= srch_d;
      out_vld_q <= out_vld_d;
      if (accept) begin
        first_q <= first_d;
        cnt_q   <= cnt_d;
        rev_q   <= rev_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= $signed(s_axis_tdata_i);
    end
    if (state_q == ST_DONE && (!out_vld_q || m_axis_tready_i)) begin
      out_q <= {1'b0, scan_lo, scan_hi, bdq_pkg::ENTRY_W'(cnt_q), drop_q,
                srch_q && scan_found};
    end
  end

  bdq_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we && accept),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  bdq_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .key_i   (key_q),
    .data_i  ($signed(rdata)),
    .found_o (scan_found),
    .hi_o    (scan_hi),
    .lo_o    (scan_lo)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: design/bdq_store.sv
`timescale 1ns / 1ps

module bdq_store #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [bdq_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [bdq_pkg::DATA_W-1:0] rdata_o
);

  logic [bdq_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bdq_scan.sv
`timescale 1ns / 1ps

// one entry per cycle while ctrl_i.en is set: key match (search only), running max and min
module bdq_scan (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::scan_ctrl_t               ctrl_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] key_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] data_i,
  output logic                              found_o,
  output logic signed [bdq_pkg::DATA_W-1:0] hi_o,
  output logic signed [bdq_pkg::DATA_W-1:0] lo_o
);

  logic                              hit_q, hit_d;
  logic signed [bdq_pkg::DATA_W-1:0] hi_q, hi_d;
  logic signed [bdq_pkg::DATA_W-1:0] lo_q, lo_d;

  always_comb begin
    hit_d = hit_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctrl_i.clr) begin
      hit_d = 1'b0;
      hi_d  = bdq_pkg::INT_MIN;
      lo_d  = bdq_pkg::INT_MAX;
    end else if (ctrl_i.en) begin
      if (ctrl_i.search && (data_i == key_i)) begin
        hit_d = 1'b1;
      end
      if (data_i > hi_q) begin
        hi_d = data_i;
      end
      if (data_i < lo_q) begin
        lo_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      hi_q  <= bdq_pkg::INT_MIN;
      lo_q  <= bdq_pkg::INT_MAX;
    end else begin
      hit_q <= hit_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  assign found_o = hit_q;
  assign hi_o    = hi_q;
  assign lo_o    = lo_q;

endmodule
